// File: rtl/sync_clock_multiplier_macros.svh
// Assertion macros shared by the sync clock multiplier RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef SYNC_CLOCK_MULTIPLIER_MACROS_SVH
`define SYNC_CLOCK_MULTIPLIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/scm_pkg.sv
// Package for the sync clock multiplier: widths, register indexes,
// shared structs and time helper functions. Depends on nothing.
`default_nettype none

package scm_pkg;

  localparam int TIME_W       = 64;
  localparam int STAMP_W      = 32;
  localparam int PULSE_DEB_W  = 16;
  localparam int DETECT_DEB_W = 20;
  localparam int CFG_DATA_W   = 20;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_DEBOUNCE = 2'd1;

  localparam logic [PULSE_DEB_W-1:0]  PULSE_DEB_RESET  = 16'd1000;
  localparam logic [DETECT_DEB_W-1:0] DETECT_DEB_RESET = 20'd50000;

  // Period divider works on 16-bit digits, each with a quotient step and a remainder step.
  localparam int DIGIT_W   = 16;
  localparam int N_DIGITS  = TIME_W / DIGIT_W;
  localparam int STEP_W    = $clog2(2 * N_DIGITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * N_DIGITS - 1);

  typedef struct packed {
    logic               valid;
    logic               physical;
    logic [STAMP_W-1:0] time_us;
  } tick_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] from_t,
                                                input logic [TIME_W-1:0] to_t);
    return (to_t >= from_t) ? (to_t - from_t) : '0;
  endfunction

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/scm_channels_if.sv
// Valid/ready channel interfaces for polls and results.
// Depends on scm_pkg for the field widths.
`default_nettype none

interface scm_poll_if;
  logic                       valid;
  logic                       ready;
  logic [scm_pkg::TIME_W-1:0] now_us;
  logic                       sync_level;
  logic                       detect_level;

  modport source (output valid, output now_us, output sync_level,
                  output detect_level, input ready);
  modport sink   (input valid, input now_us, input sync_level,
                  input detect_level, output ready);
endinterface

interface scm_result_if;
  logic                        valid;
  logic                        ready;
  logic                        tick_valid;
  logic                        tick_physical;
  logic [scm_pkg::STAMP_W-1:0] tick_time_us;
  logic                        cable_connected;

  modport source (output valid, output tick_valid, output tick_physical,
                  output tick_time_us, output cable_connected, input ready);
  modport sink   (input valid, input tick_valid, input tick_physical,
                  input tick_time_us, input cable_connected, output ready);
endinterface

`default_nettype wire

// File: rtl/scm_divider.sv
// Divides a 64-bit period by the constant multiplier, one 16-bit digit
// at a time, using a reciprocal multiply. Depends on scm_pkg.
`default_nettype none

module scm_divider #(
  parameter int MULTIPLIER = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [scm_pkg::TIME_W-1:0] dividend,
  output scm_pkg::div_status_t            status,
  output logic      [scm_pkg::TIME_W-1:0] quotient
);

  `include "sync_clock_multiplier_macros.svh"

  localparam int REM_W = $clog2(MULTIPLIER);
  localparam int V_W   = REM_W + scm_pkg::DIGIT_W;
  localparam int SHIFT = V_W + REM_W;
  localparam logic [SHIFT-1:0] RECIP =
    SHIFT'(((64'd1 << SHIFT) + MULTIPLIER - 1) / MULTIPLIER);

  logic                              busy;
  logic                              done;
  logic [scm_pkg::STEP_W-1:0]        step;
  logic [scm_pkg::TIME_W-1:0]        dvd;
  logic [REM_W-1:0]                  rem;
  logic [V_W-1:0]                    part;
  logic [scm_pkg::DIGIT_W-1:0]       qdigit;

  logic [V_W-1:0]                    part_next;
  logic [V_W+SHIFT-1:0]              prod;
  logic [V_W-1:0]                    back;
  logic [V_W-1:0]                    rem_full;

  assign part_next = {rem, dvd[scm_pkg::TIME_W-1 -: scm_pkg::DIGIT_W]};
  assign prod      = {{SHIFT{1'b0}}, part_next} * {{V_W{1'b0}}, RECIP};
  assign back      = {{REM_W{1'b0}}, qdigit} * V_W'(MULTIPLIER);
  assign rem_full  = part - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == scm_pkg::LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      if (!step[0]) begin
        part   <= part_next;
        qdigit <= prod[SHIFT +: scm_pkg::DIGIT_W];
      end else begin
        rem      <= rem_full[REM_W-1:0];
        quotient <= {quotient[scm_pkg::TIME_W-scm_pkg::DIGIT_W-1:0], qdigit};
        dvd      <= {dvd[scm_pkg::TIME_W-scm_pkg::DIGIT_W-1:0],
                     {scm_pkg::DIGIT_W{1'b0}}};
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

  `SCM_ASSERT_SAME(a_start_idle, start, !busy && !done, "divider started while in use")
  `SCM_ASSERT_NEXT(a_done_after_last, busy && step == scm_pkg::LAST_STEP, done && !busy, "divider missed its last digit")

endmodule

`default_nettype wire

// File: rtl/scm_detect.sv
// Cable-detect debounce: a level is taken once it has been stable for
// longer than the configured time. Depends on scm_pkg.
`default_nettype none

module scm_detect (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step,
  input  wire logic [scm_pkg::TIME_W-1:0]       now_us,
  input  wire logic                             detect_level,
  input  wire logic [scm_pkg::DETECT_DEB_W-1:0] detect_settle_us,
  output logic                                  cable_connected
);

  logic                       prev_raw;
  logic [scm_pkg::TIME_W-1:0] change_time;
  logic                       change_valid;
  logic                       stable;

  logic [scm_pkg::TIME_W-1:0] change_time_next;
  logic                       stable_next;

  always_comb begin
    change_time_next = (!change_valid || detect_level != prev_raw) ? now_us : change_time;
    stable_next      = stable;
    if (scm_pkg::elapsed(change_time_next, now_us) >
        {{(scm_pkg::TIME_W-scm_pkg::DETECT_DEB_W){1'b0}}, detect_settle_us}) begin
      stable_next = detect_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw     <= 1'b1;
      change_time  <= '0;
      change_valid <= 1'b0;
      stable       <= 1'b1;
    end else if (step) begin
      prev_raw     <= detect_level;
      change_time  <= change_time_next;
      change_valid <= 1'b1;
      stable       <= stable_next;
    end
  end

  assign cable_connected = !stable_next;

endmodule

`default_nettype wire

// File: rtl/scm_tick.sv
// Sync-edge debounce, period measurement and interpolated tick schedule.
// Depends on scm_pkg and scm_divider.
`default_nettype none

module scm_tick #(
  parameter int MULTIPLIER = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic [scm_pkg::TIME_W-1:0]      now_us,
  input  wire logic                            sync_level,
  input  wire logic [scm_pkg::PULSE_DEB_W-1:0] pulse_low_us,
  output scm_pkg::tick_t                       tick,
  output logic                                 busy
);

  `include "sync_clock_multiplier_macros.svh"

  localparam int CNT_W = $clog2(MULTIPLIER);
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(MULTIPLIER - 1);

  logic                       wait_low_mode;
  logic [scm_pkg::TIME_W-1:0] low_start_time;
  logic                       low_start_valid;
  logic [scm_pkg::TIME_W-1:0] last_edge_time;
  logic                       last_edge_valid;
  logic [scm_pkg::TIME_W-1:0] tick_interval;
  logic [CNT_W-1:0]           interp_count;
  logic [scm_pkg::TIME_W-1:0] next_tick_time;
  logic                       next_tick_valid;

  logic                       wait_low_mode_next;
  logic [scm_pkg::TIME_W-1:0] low_start_time_next;
  logic                       low_start_valid_next;
  logic [CNT_W-1:0]           interp_count_next;
  logic [scm_pkg::TIME_W-1:0] next_tick_time_next;
  logic                       next_tick_valid_next;
  logic [CNT_W-1:0]           count_inc;
  logic                       phys;
  logic                       interp_hit;

  logic                       div_start;
  scm_pkg::div_status_t       div_status;
  logic [scm_pkg::TIME_W-1:0] div_quotient;

  scm_divider #(.MULTIPLIER(MULTIPLIER)) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scm_pkg::elapsed(last_edge_time, now_us)),
    .status   (div_status),
    .quotient (div_quotient)
  );

  assign busy      = div_status.busy || div_status.done;
  assign phys      = !wait_low_mode && sync_level;
  assign div_start = step && phys && last_edge_valid;
  assign count_inc = interp_count + 1'b1;
  assign interp_hit = !phys && next_tick_valid && interp_count < LAST_COUNT &&
                      now_us >= next_tick_time;

  always_comb begin
    wait_low_mode_next   = wait_low_mode;
    low_start_time_next  = low_start_time;
    low_start_valid_next = low_start_valid;
    interp_count_next    = interp_count;
    next_tick_time_next  = next_tick_time;
    next_tick_valid_next = next_tick_valid;

    if (!wait_low_mode) begin
      if (sync_level) begin
        // The new schedule is set when the divider returns the interval.
        wait_low_mode_next   = 1'b1;
        low_start_valid_next = 1'b0;
        if (!last_edge_valid) begin
          next_tick_valid_next = 1'b0;
        end
      end
    end else if (!sync_level) begin
      if (!low_start_valid) begin
        low_start_time_next  = now_us;
        low_start_valid_next = 1'b1;
      end
      if (scm_pkg::elapsed(low_start_time_next, now_us) >
          {{(scm_pkg::TIME_W-scm_pkg::PULSE_DEB_W){1'b0}}, pulse_low_us}) begin
        wait_low_mode_next = 1'b0;
      end
    end else begin
      low_start_valid_next = 1'b0;
    end

    if (interp_hit) begin
      interp_count_next = count_inc;
      if (count_inc < LAST_COUNT && tick_interval != '0) begin
        next_tick_time_next = scm_pkg::sat_add(next_tick_time, tick_interval);
      end else begin
        next_tick_valid_next = 1'b0;
      end
    end

    tick.valid    = phys || interp_hit;
    tick.physical = phys;
    tick.time_us  = phys ? now_us[scm_pkg::STAMP_W-1:0] :
                    interp_hit ? next_tick_time[scm_pkg::STAMP_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_low_mode   <= 1'b1;
      low_start_time  <= '0;
      low_start_valid <= 1'b0;
      last_edge_time  <= '0;
      last_edge_valid <= 1'b0;
      tick_interval   <= '0;
      interp_count    <= '0;
      next_tick_time  <= '0;
      next_tick_valid <= 1'b0;
    end else if (step) begin
      wait_low_mode   <= wait_low_mode_next;
      low_start_time  <= low_start_time_next;
      low_start_valid <= low_start_valid_next;
      interp_count    <= interp_count_next;
      next_tick_time  <= next_tick_time_next;
      next_tick_valid <= next_tick_valid_next;
      if (phys) begin
        last_edge_time  <= now_us;
        last_edge_valid <= 1'b1;
      end
    end else if (div_status.done) begin
      tick_interval <= div_quotient;
      if (div_quotient != '0) begin
        interp_count    <= '0;
        next_tick_time  <= scm_pkg::sat_add(last_edge_time, div_quotient);
        next_tick_valid <= 1'b1;
      end else begin
        next_tick_valid <= 1'b0;
      end
    end
  end

  `SCM_ASSERT_SAME(a_no_poll_while_dividing, step, !div_status.busy && !div_status.done, "poll taken while the period divide is open")
  `SCM_ASSERT_NEXT(a_edge_rearms_debounce, step && phys, wait_low_mode && !low_start_valid, "physical edge did not rearm the debounce")

endmodule

`default_nettype wire

// File: rtl/sync_clock_multiplier.sv
// Channel     Dir  Handshake      Contents
// poll        in   valid/ready    now_us, sync_level, detect_level
// result      out  valid/ready    tick_valid, tick_physical, tick_time_us, cable_connected
// cfg         in   cfg_we         cfg_index, cfg_data
//
// One poll per cycle unless the result or the divider stalls; the poll is registered in
// the input register and its result in the output register. A physical edge after an
// earlier one holds the next poll while the divider works through four 16-bit digits.
// Reset is synchronous; there is no clearing pass.
// A stalled result holds in its register while one more poll waits in the input register.
// Top level of the sync clock multiplier; depends on scm_pkg, the channel
// interfaces, scm_tick and scm_detect.
`default_nettype none

module sync_clock_multiplier #(
  parameter int MULTIPLIER = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  scm_poll_if.sink                               poll,
  scm_result_if.source                           result,
  input  wire logic                              cfg_we,
  input  wire logic [scm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [scm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [scm_pkg::PULSE_DEB_W-1:0]  pulse_low_us;
  logic [scm_pkg::DETECT_DEB_W-1:0] detect_settle_us;

  logic                       s_valid;
  logic [scm_pkg::TIME_W-1:0] s_now_us;
  logic                       s_sync_level;
  logic                       s_detect_level;

  logic                       o_valid;
  scm_pkg::tick_t             o_tick;
  logic                       o_cable_connected;

  logic                       advance;
  logic                       tick_busy;
  scm_pkg::tick_t             tick;
  logic                       cable_connected;

  assign advance    = s_valid && !tick_busy && (!o_valid || result.ready);
  assign poll.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_low_us     <= scm_pkg::PULSE_DEB_RESET;
      detect_settle_us <= scm_pkg::DETECT_DEB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scm_pkg::CFG_PULSE_DEBOUNCE: begin
          pulse_low_us <= cfg_data[scm_pkg::PULSE_DEB_W-1:0];
        end
        scm_pkg::CFG_DETECT_DEBOUNCE: begin
          detect_settle_us <= cfg_data[scm_pkg::DETECT_DEB_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (poll.valid && poll.ready) begin
        s_valid <= 1'b1;
      end else if (advance) begin
        s_valid <= 1'b0;
      end
      if (advance) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s_now_us       <= poll.now_us;
      s_sync_level   <= poll.sync_level;
      s_detect_level <= poll.detect_level;
    end
    if (advance) begin
      o_tick            <= tick;
      o_cable_connected <= cable_connected;
    end
  end

  scm_tick #(.MULTIPLIER(MULTIPLIER)) u_tick (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .now_us       (s_now_us),
    .sync_level   (s_sync_level),
    .pulse_low_us (pulse_low_us),
    .tick         (tick),
    .busy         (tick_busy)
  );

  scm_detect u_detect (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .now_us           (s_now_us),
    .detect_level     (s_detect_level),
    .detect_settle_us (detect_settle_us),
    .cable_connected  (cable_connected)
  );

  assign result.valid           = o_valid;
  assign result.tick_valid      = o_tick.valid;
  assign result.tick_physical   = o_tick.physical;
  assign result.tick_time_us    = o_tick.time_us;
  assign result.cable_connected = o_cable_connected;

endmodule

`default_nettype wire
